[hdl/swst_pkg.sv]
// swst_pkg: shared constants, types and state codes of the sensor window statistics block
// no dependencies; every other file of the block refers to it by scoped names
`default_nettype none

package swst_pkg;

  localparam int DEPTH     = 16;
  localparam int CHANNELS  = 6;

  localparam int CH_W      = 3;
  localparam int SAMPLE_W  = 16;
  localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W    = $clog2(DEPTH + 1);
  localparam int SUM_W     = SAMPLE_W + $clog2(DEPTH);
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_DEPTH = CHANNELS * DEPTH;
  localparam int HIST_AW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  typedef logic [CH_W-1:0]            channel_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CH_IDX_W-1:0]        ch_idx_t;
  typedef logic [HIST_AW-1:0]         hist_addr_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // per-channel record kept in the channel store
  typedef struct packed {
    logic [SLOT_W-1:0]        slot;
    logic [FILL_W-1:0]        fill;
    logic signed [SUM_W-1:0]  sum;
    sample_t                  low;
    sample_t                  high;
  } chan_rec_t;

  localparam chan_rec_t REC_RESET = '{
    slot: '0, fill: '0, sum: '0, low: SAMPLE_MAX, high: SAMPLE_MIN
  };

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HREAD,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[hdl/swst_in_if.sv]
// swst_in_if: sample input channel, valid/ready with channel tag and sample
// depends on swst_pkg
`default_nettype none

interface swst_in_if;
  logic               valid;
  logic               ready;
  swst_pkg::channel_t channel;
  swst_pkg::sample_t  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

`default_nettype wire

[hdl/swst_out_if.sv]
// swst_out_if: result channel, valid/ready with channel, mean, minimum, maximum
// depends on swst_pkg
`default_nettype none

interface swst_out_if;
  logic               valid;
  logic               ready;
  swst_pkg::channel_t channel_out;
  swst_pkg::sample_t  mean;
  swst_pkg::sample_t  minimum;
  swst_pkg::sample_t  maximum;

  modport source (output valid, output channel_out, output mean, output minimum,
                  output maximum, input ready);
  modport sink   (input valid, input channel_out, input mean, input minimum,
                  input maximum, output ready);
endinterface

`default_nettype wire

[hdl/swst_hist_store.sv]
// swst_hist_store: sample history memory, one entry per channel and window slot
// depends on swst_pkg; one write and one registered read per cycle
`default_nettype none

module swst_hist_store (
  input  wire                  clk,
  input  wire                  wr_en,
  input  swst_pkg::hist_addr_t wr_addr,
  input  swst_pkg::sample_t    wr_data,
  input  wire                  rd_en,
  input  swst_pkg::hist_addr_t rd_addr,
  output swst_pkg::sample_t    rd_data
);

  swst_pkg::sample_t mem [swst_pkg::HIST_DEPTH];
  swst_pkg::sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hdl/swst_chan_store.sv]
// swst_chan_store: per-channel record memory with valid bits standing in for reset
// depends on swst_pkg; an entry never written reads as the reset record
`default_nettype none

module swst_chan_store (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  wr_en,
  input  swst_pkg::ch_idx_t    wr_idx,
  input  swst_pkg::chan_rec_t  wr_rec,
  input  wire                  rd_en,
  input  swst_pkg::ch_idx_t    rd_idx,
  output swst_pkg::chan_rec_t  rd_rec
);

  swst_pkg::chan_rec_t           mem [swst_pkg::CHANNELS];
  logic [swst_pkg::CHANNELS-1:0] vld_r;
  swst_pkg::chan_rec_t           rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_rec;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_rec = rd_vld_r ? rd_data_r : swst_pkg::REC_RESET;

endmodule

`default_nettype wire

[hdl/swst_divider.sv]
// swst_divider: serial restoring divide of the signed window sum by the fill count
// depends on swst_pkg; one quotient bit per cycle, quotient truncated toward zero
`default_nettype none

module swst_divider (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire signed [swst_pkg::SUM_W-1:0] dividend,
  input  wire [swst_pkg::FILL_W-1:0]     divisor,
  output swst_pkg::div_stat_t            stat,
  output swst_pkg::sample_t              quotient
);

  logic                           busy_r;
  logic                           done_r;
  logic                           neg_r;
  logic [swst_pkg::SUM_W-1:0]     mag_r;
  logic [swst_pkg::FILL_W-1:0]    rem_r;
  logic [swst_pkg::FILL_W-1:0]    dsr_r;
  logic [swst_pkg::DIV_CNT_W-1:0] cnt_r;

  logic [swst_pkg::FILL_W:0]      partial;
  logic [swst_pkg::FILL_W:0]      trial;
  logic                           fits;
  logic [swst_pkg::SUM_W-1:0]     abs_in;
  logic [swst_pkg::SUM_W-1:0]     q_signed;

  assign abs_in  = dividend[swst_pkg::SUM_W-1] ? (swst_pkg::SUM_W'(0) - dividend)
                                               : dividend;
  assign partial = {rem_r, mag_r[swst_pkg::SUM_W-1]};
  assign fits    = partial >= {1'b0, dsr_r};
  assign trial   = partial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[swst_pkg::SUM_W-1];
      mag_r <= abs_in;
      rem_r <= '0;
      dsr_r <= divisor;
      cnt_r <= swst_pkg::DIV_CNT_W'(swst_pkg::SUM_W - 1);
    end else if (busy_r) begin
      // quotient bits shift in where dividend bits leave
      mag_r <= {mag_r[swst_pkg::SUM_W-2:0], fits};
      rem_r <= fits ? trial[swst_pkg::FILL_W-1:0] : partial[swst_pkg::FILL_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign q_signed  = neg_r ? (swst_pkg::SUM_W'(0) - mag_r) : mag_r;
  assign quotient  = q_signed[swst_pkg::SAMPLE_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

[hdl/sensor_window_statistics_top.sv]
// sensor_window_statistics_top: per-channel sliding window mean and running min/max
// depends on swst_pkg, swst_in_if, swst_out_if, swst_hist_store, swst_chan_store,
// swst_divider
//
//   channel   dir  word                                   handshake
//   in_ch     in   channel (3b), sample (16b signed)      valid/ready
//   out_ch    out  channel_out, mean, minimum, maximum    valid/ready
//
// one word in flight: the next word is taken only once the last has passed the
// serial divider, which produces one quotient bit per cycle
// reset (rst_n low, synchronous) clears the sequencer, the output valid and the
// channel store valid bits; history read data is only used once written
// the result sits in an output register, so a new word is taken while the last
// result waits; a stalled out_ch holds the sequencer before it loads the next one
`default_nettype none

module sensor_window_statistics_top (
  input  wire               clk,
  input  wire               rst_n,
  swst_in_if.sink           in_ch,
  swst_out_if.source        out_ch
);

  swst_pkg::state_t    state_r;
  swst_pkg::state_t    state_nxt;

  // working registers of the word in flight
  swst_pkg::channel_t  ch_r;
  swst_pkg::sample_t   sample_r;
  logic                bad_r;
  swst_pkg::chan_rec_t rec_r;
  swst_pkg::chan_rec_t rec_nxt;

  // output register
  logic                out_valid_r;
  swst_pkg::channel_t  out_channel_r;
  swst_pkg::sample_t   out_mean_r;
  swst_pkg::sample_t   out_min_r;
  swst_pkg::sample_t   out_max_r;

  // store and divider hookup
  swst_pkg::chan_rec_t st_rd_rec;
  swst_pkg::sample_t   hist_rd_data;
  swst_pkg::hist_addr_t hist_addr;
  swst_pkg::ch_idx_t   ch_idx;
  swst_pkg::ch_idx_t   in_idx;
  swst_pkg::div_stat_t div_stat;
  swst_pkg::sample_t   div_quot;

  logic                in_accept;
  logic                in_good;
  logic                st_rd_en;
  logic                hist_rd_en;
  logic                upd_en;
  logic                out_load;
  logic                out_free;

  logic                full;
  logic signed [swst_pkg::SUM_W-1:0] drop;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_good   = int'(in_ch.channel) < swst_pkg::CHANNELS;
  assign in_idx    = swst_pkg::CH_IDX_W'(in_ch.channel);
  assign ch_idx    = swst_pkg::CH_IDX_W'(ch_r);
  assign out_free  = !out_valid_r || out_ch.ready;

  // entry address is channel base plus ring slot; same slot is read then written
  always_comb begin
    hist_addr = swst_pkg::HIST_AW'(int'(ch_idx) * swst_pkg::DEPTH
                                   + int'(rec_r.slot));
    if (state_r == swst_pkg::S_HREAD) begin
      hist_addr = swst_pkg::HIST_AW'(int'(ch_idx) * swst_pkg::DEPTH
                                     + int'(st_rd_rec.slot));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swst_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = in_good ? swst_pkg::S_HREAD : swst_pkg::S_DONE;
        end
      end
      swst_pkg::S_HREAD:  state_nxt = swst_pkg::S_UPDATE;
      swst_pkg::S_UPDATE: state_nxt = swst_pkg::S_DIV;
      swst_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_nxt = swst_pkg::S_DONE;
        end
      end
      swst_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = swst_pkg::S_IDLE;
        end
      end
      default: state_nxt = swst_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    st_rd_en    = 1'b0;
    hist_rd_en  = 1'b0;
    upd_en      = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      swst_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        st_rd_en    = in_ch.valid && in_good;
      end
      swst_pkg::S_HREAD:  hist_rd_en = 1'b1;
      swst_pkg::S_UPDATE: upd_en     = 1'b1;
      swst_pkg::S_DIV:    ;
      swst_pkg::S_DONE:   out_load   = out_free;
      default:            ;
    endcase
  end

  // record update: drop the oldest entry once the window is full
  assign full = int'(rec_r.fill) >= swst_pkg::DEPTH;
  assign drop = full ? swst_pkg::SUM_W'(hist_rd_data) : '0;

  always_comb begin
    rec_nxt      = rec_r;
    rec_nxt.sum  = rec_r.sum - drop + swst_pkg::SUM_W'(sample_r);
    rec_nxt.fill = full ? rec_r.fill : rec_r.fill + 1'b1;
    rec_nxt.slot = (int'(rec_r.slot) == swst_pkg::DEPTH - 1) ? '0 : rec_r.slot + 1'b1;
    if (sample_r > rec_r.high) begin
      rec_nxt.high = sample_r;
    end
    if (sample_r < rec_r.low) begin
      rec_nxt.low = sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swst_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch_r     <= in_ch.channel;
      sample_r <= in_ch.sample;
      bad_r    <= !in_good;
    end
    if (state_r == swst_pkg::S_HREAD) begin
      rec_r <= st_rd_rec;
    end else if (upd_en) begin
      rec_r <= rec_nxt;
    end
    if (out_load) begin
      out_channel_r <= ch_r;
      out_mean_r    <= bad_r ? '0 : div_quot;
      out_min_r     <= bad_r ? '0 : rec_r.low;
      out_max_r     <= bad_r ? '0 : rec_r.high;
    end
  end

  // one word at a time: the record write lands before the next read, no forwarding
  swst_chan_store u_chan_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (upd_en),
    .wr_idx  (ch_idx),
    .wr_rec  (rec_nxt),
    .rd_en   (st_rd_en),
    .rd_idx  (in_idx),
    .rd_rec  (st_rd_rec)
  );

  swst_hist_store u_hist_store (
    .clk     (clk),
    .wr_en   (upd_en),
    .wr_addr (hist_addr),
    .wr_data (sample_r),
    .rd_en   (hist_rd_en),
    .rd_addr (hist_addr),
    .rd_data (hist_rd_data)
  );

  swst_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (upd_en),
    .dividend (rec_nxt.sum),
    .divisor  (rec_nxt.fill),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.channel_out = out_channel_r;
  assign out_ch.mean        = out_mean_r;
  assign out_ch.minimum     = out_min_r;
  assign out_ch.maximum     = out_max_r;

endmodule

`default_nettype wire
